// ----- hw/rtl/hduart_pkg.sv -----
// Shared types and constants for the half-duplex UART core with receive FIFO.
// Used by hduart_fifo, the core top level and the testbench.
`default_nettype none

package hduart_pkg;

	localparam int FIFO_DEPTH = 16;
	localparam int PTR_W      = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
	localparam int CNT_W      = PTR_W + 1;
	localparam int RX_COUNT_W = 4;

	localparam int TICK_W     = 17;
	localparam int PERIOD_W   = 16;
	localparam int BITCNT_W   = 4;

	localparam logic [BITCNT_W-1:0] LAST_DATA_BIT = 4'd8;
	localparam logic [BITCNT_W-1:0] STOP_BIT      = 4'd9;

	localparam logic [7:0] CH_LF = 8'h0A;
	localparam logic [7:0] CH_CR = 8'h0D;

	localparam logic [PERIOD_W-1:0] BIT_PERIOD_RST   = 16'd1666;
	localparam logic [PERIOD_W-1:0] SAMPLE_OFFS_RST  = 16'd416;
	localparam logic                CRLF_EN_RST      = 1'b1;

	typedef enum logic [1:0] {
		MODE_IDLE = 2'd0,
		MODE_RX   = 2'd1,
		MODE_TX   = 2'd2
	} mode_t;

	typedef enum logic [1:0] {
		OP_TICK = 2'd0,
		OP_SEND = 2'd1,
		OP_READ = 2'd2,
		OP_NOP  = 2'd3
	} op_t;

	// register index, taken from paddr[3:2]
	typedef enum logic [1:0] {
		REG_BIT_PERIOD  = 2'd0,
		REG_SAMPLE_OFFS = 2'd1,
		REG_CRLF_EN     = 2'd2,
		REG_UNUSED      = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic                  full;
		logic                  empty;
		logic [RX_COUNT_W-1:0] count_n;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ----- hw/rtl/hduart_fifo.sv -----
// Receive ring FIFO: flop storage, write/read pointers, status for the core.
// Depends on hduart_pkg. Holds at most FIFO_DEPTH-1 bytes.
`default_nettype none

module hduart_fifo
	import hduart_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  wire logic [7:0]  push_data,
	input  wire logic        pop,
	output logic      [7:0]  rd_data,
	output fifo_stat_t       stat
);

	logic [7:0]       mem [FIFO_DEPTH];
	logic [7:0]       head_q;
	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W-1:0] wp_inc, rp_inc, wp_n, rp_n;
	logic [CNT_W-1:0] diff;
	logic             do_push, do_pop;

	assign wp_inc = (wp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : wp_q + 1'b1;
	assign rp_inc = (rp_q == PTR_W'(FIFO_DEPTH - 1)) ? '0 : rp_q + 1'b1;

	assign stat.full  = (wp_inc == rp_q);
	assign stat.empty = (wp_q == rp_q);

	assign do_push = push && !stat.full;
	assign do_pop  = pop && !stat.empty;

	assign wp_n = do_push ? wp_inc : wp_q;
	assign rp_n = do_pop  ? rp_inc : rp_q;

	always_comb begin
		if (wp_n >= rp_n) begin
			diff = {1'b0, wp_n} - {1'b0, rp_n};
		end else begin
			diff = {1'b0, wp_n} + CNT_W'(FIFO_DEPTH) - {1'b0, rp_n};
		end
	end
	assign stat.count_n = RX_COUNT_W'(diff);

	assign rd_data = head_q;

	always_ff @(posedge clk) begin
		if (do_push) begin
			mem[wp_q] <= push_data;
		end
	end

	// head of queue, prefetched; a byte pushed into the head slot bypasses the array
	always_ff @(posedge clk) begin
		if (do_push && wp_q == rp_n) begin
			head_q <= push_data;
		end else begin
			head_q <= mem[rp_n];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q <= '0;
			rp_q <= '0;
		end else begin
			wp_q <= wp_n;
			rp_q <= rp_n;
		end
	end

endmodule

`default_nettype wire

// ----- hw/rtl/half_duplex_uart_with_rx_fifo_core.sv -----
// Half-duplex single-wire 8N1 UART with receive FIFO; stream in/out, APB config.
// Path from input transfer to result: input register, then result register.
// Throughput: one item per cycle while the result stream is not stalled; the engine state updates in the input stage.
// Reset (arst_n low, async): engine idle, counters zero, line history high,
// FIFO empty, registers at bit_period 1666, first_sample_offset 416, crlf on.
// Depends on hduart_pkg and hduart_fifo.
`default_nettype none

module half_duplex_uart_with_rx_fifo_core
	import hduart_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	// input stream
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [0] line_in, [8:1] tx_byte, [15:9] zero
	input  wire logic [1:0]  s_tuser,  // [1:0] op
	// result stream
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic      [23:0] m_tdata,  // [0] line_drive_low, [1] send_accepted, [2] busy_res,
	                                   // [10:3] rx_data, [11] rx_valid, [15:12] rx_count,
	                                   // [16] rx_dropped, [23:17] zero
	// configuration
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready
);

	// configuration registers
	logic [PERIOD_W-1:0] bit_period_q, sample_offs_q;
	logic                crlf_en_q;
	reg_idx_t            reg_idx;

	assign pready  = 1'b1;
	assign reg_idx = reg_idx_t'(paddr[3:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bit_period_q  <= BIT_PERIOD_RST;
			sample_offs_q <= SAMPLE_OFFS_RST;
			crlf_en_q     <= CRLF_EN_RST;
		end else if (psel && penable && pwrite && pready) begin
			unique case (reg_idx)
				REG_BIT_PERIOD:  bit_period_q  <= pwdata[PERIOD_W-1:0];
				REG_SAMPLE_OFFS: sample_offs_q <= pwdata[PERIOD_W-1:0];
				REG_CRLF_EN:     crlf_en_q     <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_BIT_PERIOD:  prdata = {16'd0, bit_period_q};
			REG_SAMPLE_OFFS: prdata = {16'd0, sample_offs_q};
			REG_CRLF_EN:     prdata = {31'd0, crlf_en_q};
			default:         prdata = '0;
		endcase
	end

	// input register
	logic       valid_s1;
	op_t        op_s1;
	logic       line_s1;
	logic [7:0] byte_s1;
	logic       advance;

	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			op_s1   <= op_t'(s_tuser);
			line_s1 <= s_tdata[0];
			byte_s1 <= s_tdata[8:1];
		end
	end

	// engine state
	mode_t               mode_q, mode_n;
	logic [TICK_W-1:0]   tick_q, tick_n;
	logic [BITCNT_W-1:0] bc_q, bc_n, bc_inc;
	logic [7:0]          sh_q, sh_n;
	logic                plf_q, plf_n;
	logic                prev_q, prev_n;
	logic                accepted, push, pop, dropped;
	logic [7:0]          tx_load;
	fifo_stat_t          fstat;
	logic [7:0]          fifo_rd;

	hduart_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (sh_q),
		.pop       (pop),
		.rd_data   (fifo_rd),
		.stat      (fstat)
	);

	assign bc_inc  = bc_q + 1'b1;
	assign tx_load = (crlf_en_q && byte_s1 == CH_LF) ? CH_CR : byte_s1;

	// next state
	always_comb begin
		mode_n   = mode_q;
		tick_n   = tick_q;
		bc_n     = bc_q;
		sh_n     = sh_q;
		plf_n    = plf_q;
		prev_n   = prev_q;
		accepted = 1'b0;
		push     = 1'b0;
		pop      = 1'b0;
		dropped  = 1'b0;
		if (advance) begin
			case (op_s1)
				OP_TICK: begin
					prev_n = line_s1;
					unique case (mode_q)
						MODE_IDLE: begin
							if (prev_q && !line_s1) begin
								mode_n = MODE_RX;
								tick_n = TICK_W'(sample_offs_q) + TICK_W'(bit_period_q);
								bc_n   = '0;
								sh_n   = '0;
							end
						end
						MODE_RX: begin
							if (tick_q <= TICK_W'(1)) begin
								if (bc_inc <= LAST_DATA_BIT) begin
									bc_n   = bc_inc;
									sh_n   = {line_s1, sh_q[7:1]};
									tick_n = TICK_W'(bit_period_q);
								end else begin
									// stop sample: store byte, or drop when FIFO is full
									push    = !fstat.full;
									dropped = fstat.full;
									mode_n  = MODE_IDLE;
									tick_n  = '0;
									bc_n    = '0;
								end
							end else begin
								tick_n = tick_q - 1'b1;
							end
						end
						MODE_TX: begin
							if (tick_q <= TICK_W'(1)) begin
								if (bc_q >= STOP_BIT) begin
									if (plf_q) begin
										plf_n  = 1'b0;
										sh_n   = CH_LF;
										bc_n   = '0;
										tick_n = TICK_W'(bit_period_q);
									end else begin
										mode_n = MODE_IDLE;
										tick_n = '0;
										bc_n   = '0;
									end
								end else begin
									bc_n   = bc_inc;
									tick_n = TICK_W'(bit_period_q);
								end
							end else begin
								tick_n = tick_q - 1'b1;
							end
						end
						default: ;
					endcase
				end
				OP_SEND: begin
					if (mode_q == MODE_IDLE) begin
						accepted = 1'b1;
						plf_n    = crlf_en_q && byte_s1 == CH_LF;
						sh_n     = tx_load;
						bc_n     = '0;
						tick_n   = TICK_W'(bit_period_q);
						mode_n   = MODE_TX;
					end
				end
				OP_READ: pop = !fstat.empty;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= MODE_IDLE;
			tick_q <= '0;
			bc_q   <= '0;
			sh_q   <= '0;
			plf_q  <= 1'b0;
			prev_q <= 1'b1;
		end else begin
			mode_q <= mode_n;
			tick_q <= tick_n;
			bc_q   <= bc_n;
			sh_q   <= sh_n;
			plf_q  <= plf_n;
			prev_q <= prev_n;
		end
	end

	// result fields, taken from the updated state
	logic                  drive_low, busy;
	logic [BITCNT_W-1:0]   bit_idx;
	logic [7:0]            rx_data;
	logic [RX_COUNT_W-1:0] rx_count;

	always_comb begin
		bit_idx   = bc_n - 1'b1;
		drive_low = 1'b0;
		if (mode_n == MODE_TX) begin
			if (bc_n == '0) begin
				drive_low = 1'b1;  // start bit
			end else if (bc_n <= LAST_DATA_BIT) begin
				drive_low = !sh_n[bit_idx[2:0]];
			end
		end
		busy     = (mode_n != MODE_IDLE);
		rx_data  = pop ? fifo_rd : 8'd0;
		rx_count = fstat.count_n;
	end

	// result register
	logic        m_valid_q;
	logic [23:0] m_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (!m_valid_q || m_tready) begin
			m_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			m_data_q <= {7'd0, dropped, rx_count, pop, rx_data, busy, accepted, drive_low};
		end
	end

	assign m_tvalid = m_valid_q;
	assign m_tdata  = m_data_q;

endmodule

`default_nettype wire

// ----- hw/rtl/hduart_checker.sv -----
// Port-level checks for the half-duplex UART core, attached by bind.
// Depends on nothing but the top level's ports.
`default_nettype none

module hduart_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [23:0] m_tdata
);

	// a result waiting on the consumer holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// an accepted send always opens with the start bit
	a_send_start: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[1] |-> m_tdata[2] && m_tdata[0])
		else $error("accepted send without start bit");

	// the line is only driven while the engine is busy
	a_drive_busy: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[0] |-> m_tdata[2])
		else $error("line driven while idle");

	// a dropped byte ends reception, so the engine is idle
	a_drop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[16] |-> !m_tdata[2] && !m_tdata[11] && !m_tdata[1])
		else $error("drop flagged with busy engine or other op");

	// no byte on a failed read
	a_rx_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tdata[11] |-> m_tdata[10:3] == 8'd0)
		else $error("rx_data nonzero without rx_valid");

endmodule

bind half_duplex_uart_with_rx_fifo_core hduart_checker u_hduart_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

// ----- tb/half_duplex_uart_with_rx_fifo_core_tb.sv -----
// Self-checking testbench for half_duplex_uart_with_rx_fifo_core: serial frames, sends,
// FIFO reads and register writes, with every result word predicted and compared per field.
// Depends on hduart_pkg and the core RTL.

module half_duplex_uart_with_rx_fifo_core_tb
	import hduart_pkg::*;
();

	localparam int CYCLE_LIMIT   = 200000;
	localparam int SETTLE_CYCLES = 8;
	localparam int MAX_REPORTS   = 10;

	// result word, bit 0 first: drive_low up to pad
	typedef struct packed {
		logic [6:0]            pad;
		logic                  dropped;
		logic [RX_COUNT_W-1:0] count;
		logic                  valid;
		logic [7:0]            data;
		logic                  busy;
		logic                  accepted;
		logic                  drive_low;
	} uart_result_t;

	class uart_line_model;
		logic [PERIOD_W-1:0] bit_period;
		logic [PERIOD_W-1:0] sample_offs;
		logic                crlf_en;
		mode_t               mode;
		logic [TICK_W-1:0]   tick_cnt;
		logic [BITCNT_W-1:0] bit_cnt;
		logic [7:0]          shreg;
		logic                lf_pending;
		logic                prev_line;
		logic [7:0]          rx_mem [FIFO_DEPTH];
		int                  wr_ptr;
		int                  rd_ptr;
		uart_result_t        pending_results[$];
		int                  errors;

		function new();
			bit_period = BIT_PERIOD_RST;
			sample_offs = SAMPLE_OFFS_RST;
			crlf_en = CRLF_EN_RST;
			mode = MODE_IDLE;
			tick_cnt = '0;
			bit_cnt = '0;
			shreg = '0;
			lf_pending = 1'b0;
			prev_line = 1'b1;
			wr_ptr = 0;
			rd_ptr = 0;
			errors = 0;
		endfunction

		function void set_reg(reg_idx_t idx, logic [31:0] v);
			case (idx)
			REG_BIT_PERIOD: bit_period = v[PERIOD_W-1:0];
			REG_SAMPLE_OFFS: sample_offs = v[PERIOD_W-1:0];
			REG_CRLF_EN: crlf_en = v[0];
			default: ;
			endcase
		endfunction

		function void mismatch(string what, logic [31:0] want, logic [31:0] got);
			if (errors < MAX_REPORTS)
				$display("mismatch %s: expected %0h, got %0h", what, want, got);
			errors++;
		endfunction

		function int pending();
			return pending_results.size();
		endfunction

		function void load_tx(logic [7:0] b);
			shreg = b;
			bit_cnt = '0;
			tick_cnt = {1'b0, bit_period};
			mode = MODE_TX;
		endfunction

		// one line sample; returns 1 when a finished byte found the FIFO full
		function logic line_tick(logic line);
			logic dropped;
			int nxt;
			dropped = 1'b0;
			case (mode)
			MODE_IDLE: begin
				if (prev_line && !line) begin
					mode = MODE_RX;
					tick_cnt = {1'b0, sample_offs} + {1'b0, bit_period};
					bit_cnt = '0;
					shreg = '0;
				end
			end
			MODE_RX: begin
				if (tick_cnt <= 1) begin
					bit_cnt = bit_cnt + 1'b1;
					if (bit_cnt <= LAST_DATA_BIT) begin
						shreg = {line, shreg[7:1]};
						tick_cnt = {1'b0, bit_period};
					end else begin
						// stop sample: level ignored, one slot kept free
						nxt = (wr_ptr + 1) % FIFO_DEPTH;
						if (nxt != rd_ptr) begin
							rx_mem[wr_ptr[PTR_W-1:0]] = shreg;
							wr_ptr = nxt;
						end else begin
							dropped = 1'b1;
						end
						mode = MODE_IDLE;
						tick_cnt = '0;
						bit_cnt = '0;
					end
				end else begin
					tick_cnt = tick_cnt - 1'b1;
				end
			end
			default: begin
				if (tick_cnt <= 1) begin
					if (bit_cnt >= STOP_BIT) begin
						if (lf_pending) begin
							lf_pending = 1'b0;
							load_tx(CH_LF);
						end else begin
							mode = MODE_IDLE;
							tick_cnt = '0;
							bit_cnt = '0;
						end
					end else begin
						bit_cnt = bit_cnt + 1'b1;
						tick_cnt = {1'b0, bit_period};
					end
				end else begin
					tick_cnt = tick_cnt - 1'b1;
				end
			end
			endcase
			prev_line = line;
			return dropped;
		endfunction

		function void take_item(op_t op, logic line, logic [7:0] b);
			uart_result_t r;
			r = '0;
			case (op)
			OP_TICK: r.dropped = line_tick(line);
			OP_SEND: begin
				if (mode == MODE_IDLE) begin
					r.accepted = 1'b1;
					lf_pending = crlf_en && (b == CH_LF);
					load_tx(lf_pending ? CH_CR : b);
				end
			end
			OP_READ: begin
				if (wr_ptr != rd_ptr) begin
					r.data = rx_mem[rd_ptr[PTR_W-1:0]];
					r.valid = 1'b1;
					rd_ptr = (rd_ptr + 1) % FIFO_DEPTH;
				end
			end
			default: ;
			endcase
			if (mode == MODE_TX) begin
				if (bit_cnt == 0)
					r.drive_low = 1'b1;
				else if (bit_cnt <= LAST_DATA_BIT)
					r.drive_low = ~shreg[3'(bit_cnt - 1'b1)];
			end
			r.busy = (mode != MODE_IDLE);
			r.count = RX_COUNT_W'((wr_ptr - rd_ptr + FIFO_DEPTH) % FIFO_DEPTH);
			pending_results.push_back(r);
		endfunction

		function void check_result(logic [23:0] word);
			uart_result_t got, want;
			got = word;
			if (pending_results.size() == 0) begin
				mismatch("result with nothing pending", 32'd0, {8'd0, word});
				return;
			end
			want = pending_results.pop_front();
			if (got.drive_low !== want.drive_low)
				mismatch("line_drive_low", 32'(want.drive_low), 32'(got.drive_low));
			if (got.accepted !== want.accepted)
				mismatch("send_accepted", 32'(want.accepted), 32'(got.accepted));
			if (got.busy !== want.busy)
				mismatch("busy_res", 32'(want.busy), 32'(got.busy));
			if (got.data !== want.data)
				mismatch("rx_data", 32'(want.data), 32'(got.data));
			if (got.valid !== want.valid)
				mismatch("rx_valid", 32'(want.valid), 32'(got.valid));
			if (got.count !== want.count)
				mismatch("rx_count", 32'(want.count), 32'(got.count));
			if (got.dropped !== want.dropped)
				mismatch("rx_dropped", 32'(want.dropped), 32'(got.dropped));
			if (got.pad !== want.pad)
				mismatch("tdata padding", 32'(want.pad), 32'(got.pad));
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;

	bit             stall_en = 1'b1;
	int             items_sent = 0;
	int             cycles = 0;
	uart_line_model line_model;

	half_duplex_uart_with_rx_fifo_core uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready)
	);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(negedge clk) begin
		m_tready <= !stall_en || ($urandom_range(99) >= 31);
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			line_model.check_result(m_tdata);
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	// called at a falling edge; returns at the falling edge after the transfer
	task automatic push_item(op_t op, logic line, logic [7:0] b);
		while (stall_en && $urandom_range(99) < 31) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {7'd0, b, line};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		line_model.take_item(op, line, b);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic wait_drained();
		s_tvalid <= 1'b0;
		while (line_model.pending() != 0) @(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// write, then read back through the same port
	task automatic write_reg(reg_idx_t idx, logic [31:0] val);
		logic [31:0] want;
		want = (idx == REG_CRLF_EN) ? {31'd0, val[0]} : {16'd0, val[15:0]};
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= val;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		line_model.set_reg(idx, val);
		@(negedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		if (prdata !== want)
			line_model.mismatch("register readback", want, prdata);
		@(negedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		@(negedge clk);
	endtask

	task automatic set_config(int period, int offs, bit crlf);
		wait_drained();
		write_reg(REG_BIT_PERIOD, period);
		write_reg(REG_SAMPLE_OFFS, offs);
		write_reg(REG_CRLF_EN, {31'd0, crlf});
	endtask

	// idle-high ticks until the engine has finished its current job
	task automatic settle_line();
		while (line_model.mode != MODE_IDLE) push_item(OP_TICK, 1'b1, 8'($urandom));
	endtask

	function automatic logic frame_level(logic [7:0] b, int p, int j);
		int k;
		k = j / p - 1;
		if (j < p)
			return 1'b0;
		if (k < 8)
			return b[k[2:0]];
		return 1'b1;
	endfunction

	// start bit, data LSB first, stop; len below a full frame gives a broken one
	task automatic rx_frame(logic [7:0] b, int len);
		int p;
		p = int'(line_model.bit_period);
		repeat ($urandom_range(1, 3)) push_item(OP_TICK, 1'b1, 8'($urandom));
		for (int j = 0; j < len; j++)
			push_item(OP_TICK, frame_level(b, p, j), 8'($urandom));
	endtask

	task automatic tx_burst();
		logic [7:0] b;
		int span;
		b = ($urandom_range(3) == 0) ? CH_LF : 8'($urandom);
		span = 10 * int'(line_model.bit_period) * ((line_model.crlf_en && b == CH_LF) ? 2 : 1);
		span = span + $urandom_range(0, 4);
		push_item(OP_SEND, 1'($urandom_range(1)), b);
		for (int j = 0; j < span; j++) begin
			if ($urandom_range(19) == 0)
				push_item(OP_SEND, 1'($urandom_range(1)), 8'($urandom));
			push_item(OP_TICK, $urandom_range(99) < 80, 8'($urandom));
		end
	endtask

	task automatic mixed_traffic(int budget);
		int stop_at;
		int pick;
		int full_len;
		stop_at = items_sent + budget;
		full_len = 10 * int'(line_model.bit_period);
		while (items_sent < stop_at) begin
			pick = $urandom_range(99);
			if (pick < 45)
				rx_frame(8'($urandom), full_len);
			else if (pick < 55)
				rx_frame(8'($urandom), $urandom_range(1, full_len - 1));
			else if (pick < 70)
				tx_burst();
			else if (pick < 85)
				repeat ($urandom_range(1, 3))
					push_item(OP_READ, 1'($urandom_range(1)), 8'($urandom));
			else if (pick < 90)
				push_item(OP_NOP, 1'($urandom_range(1)), 8'($urandom));
			else
				repeat ($urandom_range(1, 8))
					push_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom));
		end
		settle_line();
	endtask

	initial begin
		int period;
		line_model = new();
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// reset settings: status only, nothing started
		push_item(OP_NOP, 1'b1, 8'hFF);
		push_item(OP_READ, 1'b0, 8'h00);
		push_item(OP_TICK, 1'b1, 8'h00);

		set_config(8, 0, 1'b1);
		push_item(OP_SEND, 1'b0, CH_LF);
		push_item(OP_SEND, 1'b1, 8'hFF);   // engine busy: ignored
		push_item(OP_TICK, 1'b0, 8'h00);   // falling edge while transmitting
		push_item(OP_TICK, 1'b1, 8'hFF);
		push_item(OP_READ, 1'b1, 8'hA5);   // empty FIFO
		push_item(OP_NOP, 1'b0, 8'h00);
		settle_line();

		// fill the FIFO past its limit without reading, no idling on either side;
		// with period 8 and offset 0 the stop sample lands on the 73rd tick
		stall_en = 1'b0;
		for (int n = 0; n < FIFO_DEPTH; n++)
			rx_frame((n == 0) ? 8'h00 : (n == 1) ? 8'hFF : 8'($urandom), 73);
		stall_en = 1'b1;
		repeat (FIFO_DEPTH) push_item(OP_READ, 1'($urandom_range(1)), 8'($urandom));

		period = $urandom_range(8, 12);
		set_config(period, $urandom_range(0, period - 1), 1'b0);
		mixed_traffic(25);

		// widest counters: reception armed but never finishes
		set_config(65535, 65535, 1'b0);
		push_item(OP_TICK, 1'b1, 8'h3C);
		push_item(OP_TICK, 1'b0, 8'hC3);
		repeat (30) push_item(OP_TICK, 1'($urandom_range(1)), 8'($urandom));
		push_item(OP_SEND, 1'b1, 8'h81);
		push_item(OP_READ, 1'b0, 8'h7E);
		push_item(OP_NOP, 1'b1, 8'h00);

		wait_drained();
		if (line_model.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

// ----- filelist.f -----
hw/rtl/hduart_pkg.sv
hw/rtl/hduart_fifo.sv
hw/rtl/half_duplex_uart_with_rx_fifo_core.sv
hw/rtl/hduart_checker.sv
tb/half_duplex_uart_with_rx_fifo_core_tb.sv
